@@ src/ps2_mouse_cursor_tracker_defines.svh @@
// Assertion helpers shared by the tracker modules.
// Both expect clk_i and rst_ni in scope.
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

// same-cycle implication
`define PMCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pmct_pkg.sv @@
`default_nettype none
package pmct_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 12;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned DeltaW = 11;  // -511..510
  localparam int unsigned SumW   = 14;  // position plus delta, signed
  localparam int unsigned BtnW   = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [SizeW-1:0] ScreenWidthReset  = SizeW'(1024);
  localparam logic [SizeW-1:0] ScreenHeightReset = SizeW'(768);

  // flag byte bits
  localparam int unsigned FlagLeft   = 0;
  localparam int unsigned FlagRight  = 1;
  localparam int unsigned FlagMiddle = 2;
  localparam int unsigned FlagSync   = 3;
  localparam int unsigned FlagXSign  = 4;
  localparam int unsigned FlagYSign  = 5;
  localparam int unsigned FlagXOvf   = 6;
  localparam int unsigned FlagYOvf   = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BTN_NONE   = 2'd0,
    BTN_LEFT   = 2'd1,
    BTN_MIDDLE = 2'd2,
    BTN_RIGHT  = 2'd3
  } button_e;

  typedef enum logic [1:0] {
    ST_SKIP,
    ST_FLAG,
    ST_DX,
    ST_DY
  } front_state_e;

  typedef struct packed {
    logic [ByteW-1:0] flags;
    logic [ByteW-1:0] dx;
    logic [ByteW-1:0] dy;
  } pkt_t;

  function automatic logic signed [DeltaW-1:0] delta9(logic [ByteW-1:0] mag, logic neg,
                                                      logic ovf);
    logic signed [DeltaW-1:0] d;
    logic signed [DeltaW-1:0] step;
    d    = $signed({{(DeltaW-ByteW){neg}}, mag});
    step = $signed(DeltaW'(255));
    if (ovf) begin
      d = neg ? d - step : d + step;
    end
    return d;
  endfunction

  function automatic logic [PosW-1:0] clamp_pos(logic signed [SumW-1:0] v,
                                                logic [SizeW-1:0] size);
    logic [PosW-1:0] hi;
    logic signed [SumW-1:0] one;
    one = $signed(SumW'(1));
    if (size < SizeW'(2)) begin
      hi = PosW'(1);
    end else if (size > SizeW'(2 ** PosW)) begin
      hi = '1;
    end else begin
      hi = PosW'(size - SizeW'(1));
    end
    if (v < one) begin
      return PosW'(1);
    end else if (v > $signed(SumW'(hi))) begin
      return hi;
    end
    return v[PosW-1:0];
  endfunction

  function automatic button_e pick_button(logic [ByteW-1:0] flags);
    button_e b;
    if (flags[FlagLeft]) begin
      b = BTN_LEFT;
    end else if (flags[FlagMiddle]) begin
      b = BTN_MIDDLE;
    end else if (flags[FlagRight]) begin
      b = BTN_RIGHT;
    end else begin
      b = BTN_NONE;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ src/pmct_front.sv @@
`default_nettype none
`include "ps2_mouse_cursor_tracker_defines.svh"
module pmct_front import pmct_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] mouse_byte_i,
  output logic                  push_o,
  output pkt_t                  pkt_o
);

  front_state_e state_q, state_d;
  logic [ByteW-1:0] flag_q, dx_q;
  logic             flag_we, dx_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SKIP;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_q <= mouse_byte_i;
    end
    if (dx_we) begin
      dx_q <= mouse_byte_i;
    end
  end

  always_comb begin
    state_d = state_q;
    flag_we = 1'b0;
    dx_we   = 1'b0;
    push_o  = 1'b0;
    if (accept_i) begin
      unique case (state_q)
        ST_SKIP: state_d = ST_FLAG;
        ST_FLAG: begin
          // resync: only a byte with the sync bit set can open a packet
          if (mouse_byte_i[FlagSync]) begin
            flag_we = 1'b1;
            state_d = ST_DX;
          end
        end
        ST_DX: begin
          dx_we   = 1'b1;
          state_d = ST_DY;
        end
        ST_DY: begin
          push_o  = 1'b1;
          state_d = ST_FLAG;
        end
        default: state_d = ST_FLAG;
      endcase
    end
  end

  assign pkt_o = '{flags: flag_q, dx: dx_q, dy: mouse_byte_i};

  `PMCT_ASSERT_NEXT(a_skip_once, accept_i && state_q == ST_SKIP, state_q == ST_FLAG,
                    "front left skip state wrongly")
  `PMCT_ASSERT_NOW(a_push_third, push_o, state_q == ST_DY && accept_i,
                   "packet pushed outside third byte")
  `PMCT_ASSERT_NEXT(a_no_return_skip, state_q != ST_SKIP, state_q != ST_SKIP,
                    "front re-entered skip state")

endmodule
`default_nettype wire

@@ src/pmct_fifo.sv @@
`default_nettype none
`include "ps2_mouse_cursor_tracker_defines.svh"
module pmct_fifo import pmct_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire pkt_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output pkt_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `PMCT_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `PMCT_ASSERT_NOW(a_no_underflow, pop_i, valid_o, "pop from empty queue")
  `PMCT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(Depth), "queue count out of range")

endmodule
`default_nettype wire

@@ src/pmct_back.sv @@
`default_nettype none
`include "ps2_mouse_cursor_tracker_defines.svh"
module pmct_back import pmct_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SizeW-1:0] screen_width_i,
  input  wire logic [SizeW-1:0] screen_height_i,
  input  wire logic             pkt_valid_i,
  input  wire pkt_t             pkt_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [PosW-1:0]       cursor_x_o,
  output logic [PosW-1:0]       cursor_y_o,
  output logic [BtnW-1:0]       button_o
);

  logic                     out_valid_q;
  logic [PosW-1:0]          pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [BtnW-1:0]          button_q;
  logic signed [DeltaW-1:0] dx, dy;
  logic signed [SumW-1:0]   sum_x, sum_y;

  assign pop_o = pkt_valid_i && (!out_valid_q || !out_stall_i);

  assign dx = delta9(pkt_i.dx, pkt_i.flags[FlagXSign], pkt_i.flags[FlagXOvf]);
  assign dy = delta9(pkt_i.dy, pkt_i.flags[FlagYSign], pkt_i.flags[FlagYOvf]);

  // screen y grows downward, so the mouse's y delta is subtracted
  assign sum_x = $signed(SumW'(pos_x_q)) + SumW'(dx);
  assign sum_y = $signed(SumW'(pos_y_q)) - SumW'(dy);

  assign pos_x_d = clamp_pos(sum_x, screen_width_i);
  assign pos_y_d = clamp_pos(sum_y, screen_height_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      button_q <= pick_button(pkt_i.flags);
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_x_o  = pos_x_q;
  assign cursor_y_o  = pos_y_q;
  assign button_o    = button_q;

  `PMCT_ASSERT_NOW(a_pos_in_range, out_valid_q, pos_x_q != '0 && pos_y_q != '0,
                   "cursor left the clamp range")
  `PMCT_ASSERT_NEXT(a_pos_hold, !pop_o, $stable(pos_x_q) && $stable(pos_y_q),
                    "cursor moved without a packet")
  `PMCT_ASSERT_NEXT(a_pop_shows, pop_o, out_valid_q, "popped packet not shown")

endmodule
`default_nettype wire

@@ src/ps2_mouse_cursor_tracker.sv @@
// PS/2 mouse cursor tracker.
// Input channel: one mouse byte per transaction (in_valid_i / in_stall_o /
// mouse_byte_i). The first byte after reset is dropped; a packet opens only
// on a byte with bit 3 set, and its flag, X and Y bytes are collected.
// Output channel: one transaction per completed packet with the clamped cursor
// position and the pressed button (left over middle over right).
// Configuration: cfg_we_i writes screen width (index 0) or height (index 1);
// write only while idle. Reset values are 1024 and 768.
// When the output is free, a packet's result passes the queue and then the back
// end output register after its third byte is taken. Throughput is one byte per
// cycle while in_stall_o is low, set by the front state machine and the
// one-stage back end update.
// A small packet queue sits between front and back; in_stall_o rises only
// when that queue is full, which takes a receiver stall of several packets.
// Reset clears the cursor to 0,0, the queue and the output register.
`default_nettype none
module ps2_mouse_cursor_tracker import pmct_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SizeW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ByteW-1:0]   mouse_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PosW-1:0]         cursor_x_o,
  output logic [PosW-1:0]         cursor_y_o,
  output logic [BtnW-1:0]         button_o
);

  logic [SizeW-1:0] screen_width_q, screen_height_q;
  logic             accept, push, full, pkt_valid, pop;
  pkt_t             pkt_in, pkt_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScreenWidthReset;
      screen_height_q <= ScreenHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  pmct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mouse_byte_i (mouse_byte_i),
    .push_o       (push),
    .pkt_o        (pkt_in)
  );

  pmct_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pkt_in),
    .full_o  (full),
    .valid_o (pkt_valid),
    .pop_i   (pop),
    .data_o  (pkt_out)
  );

  pmct_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .pkt_valid_i     (pkt_valid),
    .pkt_i           (pkt_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .button_o        (button_o)
  );

endmodule
`default_nettype wire
